>>> hw/rtl/sssps_pkg.sv
package sssps_pkg;

    // Fraction bits of a trial coordinate.
    localparam int FRAC_BITS_DEF = 16;

    // erand48-style generator: x' = (x * a + c) mod 2^48
    localparam logic [34:0] LCG_MUL = 35'h5_DEEC_E66D;
    localparam logic [3:0]  LCG_ADD = 4'hB;
    localparam logic [15:0] XI_LOW  = 16'h1FF1;
    localparam logic [15:0] XI_MID  = 16'hAE0D;
    localparam logic [15:0] XI_HIGH = 16'h3D2F;
    localparam logic [47:0] SEED_RST = {XI_HIGH, XI_MID, XI_LOW};
    localparam logic [1:0]  LCG_LAST_CHUNK = 2'd2;

    // Velocity law weight 128 = 2^7 on the held squared radius.
    localparam int VEL_WEIGHT_SH = 7;

    localparam int OUT_W      = 17;
    localparam int DIV_BITS   = 17;
    localparam int STEP_W     = $clog2(DIV_BITS);
    localparam logic [1:0] LAST_LANE = 2'd2;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 104;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 64;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LCG_MUL,
        CMD_LCG_LOAD,
        CMD_SQUARE,
        CMD_SQ_ADD,
        CMD_HOLD,
        CMD_RSQ,
        CMD_RSQV,
        CMD_DEN,
        CMD_NUM_LO,
        CMD_NUM_HI,
        CMD_DIV_STEP,
        CMD_VEL,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] idx;
    } t_dp_ctrl;

    typedef struct packed {
        logic pos_ok;
        logic vel_ok;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [1:0] {
        REG_SEED,
        REG_INNER,
        REG_RADIUS,
        REG_VSCALE
    } t_reg_idx;

endpackage

>>> hw/rtl/sssps_ctrl.sv
module sssps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_advance,
    output logic                 o_in_ready,
    input  sssps_pkg::t_dp_stat  i_stat,
    output sssps_pkg::t_dp_ctrl  o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LCG,
        S_LOAD,
        S_SQUARE,
        S_SQADD,
        S_DECIDE,
        S_RSQ,
        S_RSQV,
        S_DEN,
        S_NUM_LO,
        S_NUM_HI,
        S_DIV,
        S_VEL,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [1:0]                   r_k;
    logic [1:0]                   r_c;
    logic [sssps_pkg::STEP_W-1:0] r_step;
    logic                         r_vphase;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_ctrl.cmd = sssps_pkg::CMD_NOP;
        o_ctrl.idx = r_k;
        case (r_state)
            S_LCG: begin
                o_ctrl.cmd = sssps_pkg::CMD_LCG_MUL;
                o_ctrl.idx = r_c;
            end
            S_LOAD:   o_ctrl.cmd = sssps_pkg::CMD_LCG_LOAD;
            S_SQUARE: o_ctrl.cmd = sssps_pkg::CMD_SQUARE;
            S_SQADD:  o_ctrl.cmd = sssps_pkg::CMD_SQ_ADD;
            S_DECIDE: begin
                if (!r_vphase && i_stat.pos_ok) begin
                    o_ctrl.cmd = sssps_pkg::CMD_HOLD;
                end
            end
            S_RSQ:    o_ctrl.cmd = sssps_pkg::CMD_RSQ;
            S_RSQV:   o_ctrl.cmd = sssps_pkg::CMD_RSQV;
            S_DEN:    o_ctrl.cmd = sssps_pkg::CMD_DEN;
            S_NUM_LO: o_ctrl.cmd = sssps_pkg::CMD_NUM_LO;
            S_NUM_HI: o_ctrl.cmd = sssps_pkg::CMD_NUM_HI;
            S_DIV:    o_ctrl.cmd = sssps_pkg::CMD_DIV_STEP;
            S_VEL:    o_ctrl.cmd = sssps_pkg::CMD_VEL;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.cmd = sssps_pkg::CMD_EMIT;
                end
            end
            default:  o_ctrl.cmd = sssps_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_c      <= '0;
            r_step   <= '0;
            r_vphase <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in_advance) begin
                        r_k     <= '0;
                        r_c     <= '0;
                        r_state <= S_LCG;
                    end
                end
                S_LCG: begin
                    if (r_c == sssps_pkg::LCG_LAST_CHUNK) begin
                        r_c     <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_c <= r_c + 2'd1;
                    end
                end
                S_LOAD:   r_state <= S_SQUARE;
                S_SQUARE: r_state <= S_SQADD;
                S_SQADD: begin
                    if (r_k == sssps_pkg::LAST_LANE) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_LCG;
                    end
                end
                S_DECIDE: begin
                    r_k <= '0;
                    if (!r_vphase) begin
                        if (i_stat.pos_ok) begin
                            r_vphase <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else if (i_stat.vel_ok) begin
                        r_state <= S_RSQ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RSQ:    r_state <= S_RSQV;
                S_RSQV:   r_state <= S_DEN;
                S_DEN:    r_state <= S_NUM_LO;
                S_NUM_LO: r_state <= S_NUM_HI;
                S_NUM_HI: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == sssps_pkg::STEP_W'(sssps_pkg::DIV_BITS - 1)) begin
                        r_state <= S_VEL;
                    end else begin
                        r_step <= r_step + sssps_pkg::STEP_W'(1);
                    end
                end
                S_VEL: begin
                    if (r_k == sssps_pkg::LAST_LANE) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_NUM_LO;
                    end
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (i_stat.out_free) begin
                        r_vphase <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/sssps_dpath.sv
module sssps_dpath #(
    parameter int FRAC_BITS = sssps_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sssps_pkg::t_dp_ctrl                  i_ctrl,
    output sssps_pkg::t_dp_stat                  o_stat,
    input  logic                                 i_seed_load,
    input  logic [47:0]                          i_seed,
    input  logic [32:0]                          i_inner_ratio_sq,
    input  logic [15:0]                          i_radius,
    input  logic [15:0]                          i_velocity_scale,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [6*sssps_pkg::OUT_W-1:0]        o_out_data
);

    localparam int TW     = FRAC_BITS + 1;      // trial coordinate, signed
    localparam int PW     = 2 * FRAC_BITS + 1;  // one square
    localparam int SQW    = 2 * FRAC_BITS + 2;  // sum of three squares
    localparam int SHL_SQ = (2 * FRAC_BITS <= 32) ? 32 - 2 * FRAC_BITS : 0;
    localparam int SHL_IN = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam int CW     = SQW + SHL_SQ;
    localparam int DW     = 2 * FRAC_BITS + 33; // divisor
    localparam int NLW    = FRAC_BITS + 49;     // |v| * V * R^2
    localparam int NW     = 2 * FRAC_BITS + 49; // dividend
    localparam int OW     = sssps_pkg::OUT_W;
    localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * FRAC_BITS);

    function automatic logic [TW-1:0] mag_of(input logic [TW-1:0] v);
        return v[TW-1] ? TW'(~v + TW'(1)) : v;
    endfunction

    logic [47:0]        r_lcg;
    logic [47:0]        r_acc;
    logic [TW-1:0]      r_t    [3];
    logic [TW-1:0]      r_hold [3];
    logic [PW-1:0]      r_prod;
    logic [SQW-1:0]     r_sq;
    logic [SQW-1:0]     r_hsq;
    logic [31:0]        r_rsq;
    logic [47:0]        r_rv;
    logic [DW-1:0]      r_den;
    logic               r_den_zero;
    logic [NLW-1:0]     r_num;
    logic [NW-1:0]      r_rem;
    logic [NW-1:0]      r_dsh;
    logic [OW-1:0]      r_q;
    logic [OW-1:0]      r_pos  [3];
    logic [OW-1:0]      r_vel  [3];
    logic               r_out_valid;
    logic [6*OW-1:0]    r_out_data;

    logic [15:0]        lcg_chunk;
    logic [50:0]        lcg_pp;
    logic [47:0]        lcg_term;
    logic [47:0]        n_acc;
    logic [TW-1:0]      t_new;
    logic [TW-1:0]      t_sel;
    logic [TW-1:0]      t_mag;
    logic [2*TW-1:0]    sq_full;
    logic               inner_ok;
    logic               sq_le_one;
    logic [TW-1:0]      h_sel;
    logic [TW-1:0]      h_mag;
    logic [TW+15:0]     pos_prod;
    logic [OW-1:0]      pos_abs;
    logic [OW-1:0]      pos_val;
    logic [TW+23:0]     mul_lo;
    logic [TW+23:0]     mul_hi;
    logic [NLW-1:0]     n_numsum;
    logic               div_ge;
    logic [OW-1:0]      vel_val;

    // One 16-bit slice of the state times the multiplier per cycle.
    always_comb begin
        case (i_ctrl.idx)
            2'd0:    lcg_chunk = r_lcg[15:0];
            2'd1:    lcg_chunk = r_lcg[31:16];
            default: lcg_chunk = r_lcg[47:32];
        endcase
    end

    assign lcg_pp = 51'(lcg_chunk) * 51'(sssps_pkg::LCG_MUL);

    always_comb begin
        case (i_ctrl.idx)
            2'd0:    lcg_term = lcg_pp[47:0];
            2'd1:    lcg_term = {lcg_pp[31:0], 16'd0};
            default: lcg_term = {lcg_pp[15:0], 32'd0};
        endcase
    end

    assign n_acc = ((i_ctrl.idx == 2'd0) ? 48'(sssps_pkg::LCG_ADD) : r_acc) + lcg_term;

    // top FRAC_BITS+1 bits minus 2^FRAC_BITS: flip the sign bit
    assign t_new = {~r_acc[47], r_acc[46 -: FRAC_BITS]};

    assign t_sel   = r_t[i_ctrl.idx];
    assign t_mag   = mag_of(t_sel);
    assign sq_full = (2*TW)'(t_mag) * (2*TW)'(t_mag);

    assign inner_ok  = ((CW'(i_inner_ratio_sq) << SHL_IN) <= (CW'(r_sq) << SHL_SQ));
    assign sq_le_one = (r_sq <= ONE_SQ);

    assign o_stat.pos_ok   = inner_ok && sq_le_one;
    assign o_stat.vel_ok   = sq_le_one;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign h_sel    = r_hold[i_ctrl.idx];
    assign h_mag    = mag_of(h_sel);
    assign pos_prod = (TW+16)'(h_mag) * (TW+16)'(i_radius);
    assign pos_abs  = pos_prod[FRAC_BITS +: OW];
    assign pos_val  = h_sel[TW-1] ? (~pos_abs + OW'(1)) : pos_abs;

    assign mul_lo   = (TW+24)'(t_mag) * (TW+24)'(r_rv[23:0]);
    assign mul_hi   = (TW+24)'(t_mag) * (TW+24)'(r_rv[47:24]);
    assign n_numsum = r_num + (NLW'(mul_hi) << 24);

    assign div_ge  = (r_rem >= r_dsh);
    assign vel_val = r_den_zero ? '0 : (t_sel[TW-1] ? (~r_q + OW'(1)) : r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg       <= sssps_pkg::SEED_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_load) begin
                r_lcg <= i_seed;
            end else if (i_ctrl.cmd == sssps_pkg::CMD_LCG_LOAD) begin
                r_lcg <= r_acc;
            end
            if (i_ctrl.cmd == sssps_pkg::CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            sssps_pkg::CMD_LCG_MUL:  r_acc <= n_acc;
            sssps_pkg::CMD_LCG_LOAD: r_t[i_ctrl.idx] <= t_new;
            sssps_pkg::CMD_SQUARE:   r_prod <= sq_full[PW-1:0];
            sssps_pkg::CMD_SQ_ADD: begin
                r_sq <= ((i_ctrl.idx == 2'd0) ? '0 : r_sq) + SQW'(r_prod);
            end
            sssps_pkg::CMD_HOLD: begin
                r_hold <= r_t;
                r_hsq  <= r_sq;
            end
            sssps_pkg::CMD_RSQ:  r_rsq <= 32'(i_radius) * 32'(i_radius);
            sssps_pkg::CMD_RSQV: r_rv <= 48'(r_rsq) * 48'(i_velocity_scale);
            sssps_pkg::CMD_DEN: begin
                r_den      <= (DW'(r_rsq) << (2 * FRAC_BITS))
                            + (DW'(r_hsq) << sssps_pkg::VEL_WEIGHT_SH);
                r_den_zero <= (r_rsq == '0) && (r_hsq == '0);
            end
            sssps_pkg::CMD_NUM_LO: begin
                r_num               <= NLW'(mul_lo);
                r_dsh               <= NW'(r_den) << (sssps_pkg::DIV_BITS - 1);
                r_q                 <= '0;
                r_pos[i_ctrl.idx]   <= pos_val;
            end
            sssps_pkg::CMD_NUM_HI: r_rem <= NW'(n_numsum) << FRAC_BITS;
            sssps_pkg::CMD_DIV_STEP: begin
                // restoring divide, one quotient bit per cycle
                if (div_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[OW-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
            end
            sssps_pkg::CMD_VEL: r_vel[i_ctrl.idx] <= vel_val;
            sssps_pkg::CMD_EMIT: begin
                r_out_data <= {r_vel[2], r_vel[1], r_vel[0], r_pos[2], r_pos[1], r_pos[0]};
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hw/rtl/spherical_shell_point_sampler_unit.sv
// Spherical shell point sampler.
// Input stream (s_axis): one beat per trial; tdata[0] = advance. A beat with
// advance low is taken and does nothing. A beat with advance high draws three
// 48-bit generator numbers as a trial vector.
// While seeking a position, a trial inside the shell is kept and the block
// then seeks a velocity; a trial inside the unit ball completes a particle and
// one output beat (m_axis) carries position and velocity. Other trials give
// no beat.
// Timing: the three chained generator steps (three 16-bit slice multiplies
// each) set the time from one input beat to the next for a trial that gives
// no beat; three 17-step restoring divides for the velocity set the time of
// a completing trial and of its output beat. One trial is in flight at a time.
// The output register holds a finished beat while m_axis_tready is low; the
// next input beat is still taken and worked, and its result waits for the
// register to drain.
// Configuration (APB, 64-bit data): seed at 0x00, inner_ratio_sq at 0x08,
// radius at 0x10, velocity_scale at 0x18. Write only while idle.
// Reset loads the default seed, clears the phase and drops any pending beat.
module spherical_shell_point_sampler_unit #(
    parameter int FRAC_BITS = sssps_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // [0] advance, [7:1] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sssps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z,
    // [67:51] vel_x, [84:68] vel_y, [101:85] vel_z, [103:102] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sssps_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sssps_pkg::APB_AW-1:0]      paddr,
    input  logic [sssps_pkg::APB_DW-1:0]      pwdata,
    output logic [sssps_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    localparam int OW = sssps_pkg::OUT_W;

    logic [47:0]          r_seed;
    logic [32:0]          r_inner;
    logic [15:0]          r_radius;
    logic [15:0]          r_vscale;

    logic                 cfg_wr;
    sssps_pkg::t_reg_idx  cfg_idx;
    logic                 seed_load;
    sssps_pkg::t_dp_ctrl  dp_ctrl;
    sssps_pkg::t_dp_stat  dp_stat;
    logic [6*OW-1:0]      out_data;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = sssps_pkg::t_reg_idx'(paddr[4:3]);
    assign seed_load = cfg_wr && (cfg_idx == sssps_pkg::REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= sssps_pkg::SEED_RST;
            r_inner  <= '0;
            r_radius <= 16'd1;
            r_vscale <= 16'd1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sssps_pkg::REG_SEED:   r_seed   <= pwdata[47:0];
                sssps_pkg::REG_INNER:  r_inner  <= pwdata[32:0];
                sssps_pkg::REG_RADIUS: r_radius <= pwdata[15:0];
                sssps_pkg::REG_VSCALE: r_vscale <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sssps_pkg::REG_SEED:   prdata = sssps_pkg::APB_DW'(r_seed);
            sssps_pkg::REG_INNER:  prdata = sssps_pkg::APB_DW'(r_inner);
            sssps_pkg::REG_RADIUS: prdata = sssps_pkg::APB_DW'(r_radius);
            sssps_pkg::REG_VSCALE: prdata = sssps_pkg::APB_DW'(r_vscale);
            default:               prdata = '0;
        endcase
    end

    sssps_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_advance (s_axis_tdata[0]),
        .o_in_ready   (s_axis_tready),
        .i_stat       (dp_stat),
        .o_ctrl       (dp_ctrl)
    );

    sssps_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (dp_ctrl),
        .o_stat           (dp_stat),
        .i_seed_load      (seed_load),
        .i_seed           (pwdata[47:0]),
        .i_inner_ratio_sq (r_inner),
        .i_radius         (r_radius),
        .i_velocity_scale (r_vscale),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_out_data       (out_data)
    );

    assign m_axis_tdata = sssps_pkg::OUT_DATA_W'(out_data);

endmodule

>>> hw/rtl/sssps_checker.sv
module sssps_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [sssps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sssps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // a drawing beat keeps the input side closed while the trial is worked
    a_busy_after_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
        else $error("input taken while a trial is in flight");

    // a new result comes only out of a finished velocity trial
    a_emit_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a trial in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // every magnitude stays within 65535
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] != 17'h10000)
            && (m_axis_tdata[33:17] != 17'h10000)
            && (m_axis_tdata[50:34] != 17'h10000)
            && (m_axis_tdata[67:51] != 17'h10000)
            && (m_axis_tdata[84:68] != 17'h10000)
            && (m_axis_tdata[101:85] != 17'h10000)
            && (m_axis_tdata[103:102] == 2'b00))
        else $error("output field out of range");

endmodule

bind spherical_shell_point_sampler_unit sssps_checker u_sssps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
